// ----- rtl/core/sacl_pkg.sv -----
// shared types, codes and defaults of the set-associative lru cache model
package sacl_pkg;

    localparam int DEF_MAX_SET_BITS = 6;
    localparam int DEF_MAX_WAYS     = 8;
    localparam int DEF_COUNT_WIDTH  = 32;

    localparam int ADDR_W     = 64;
    localparam int TAG_W      = 64;
    localparam int MODE_W     = 2;
    localparam int OUTCOME_W  = 2;
    localparam int HITS_W     = 2;
    localparam int TOTAL_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    localparam int SET_BITS_W   = 3;
    localparam int BLOCK_BITS_W = 6;
    localparam int WAYS_CFG_W   = 4;

    localparam logic [SET_BITS_W-1:0]   SET_BITS_RST   = 3'd4;
    localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_RST = 6'd4;
    localparam logic [WAYS_CFG_W-1:0]   WAYS_RST       = 4'd1;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD   = 2'd0,
        MODE_STORE  = 2'd1,
        MODE_MODIFY = 2'd2,
        MODE_UNUSED = 2'd3
    } mode_t;

    typedef enum logic [OUTCOME_W-1:0] {
        OUTCOME_HIT   = 2'd0,
        OUTCOME_MISS  = 2'd1,
        OUTCOME_EVICT = 2'd2
    } outcome_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SET_BITS   = 2'd0,
        CFG_BLOCK_BITS = 2'd1,
        CFG_WAYS       = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic              hit;
        logic              evict;
        logic [HITS_W-1:0] hits_added;
    } lookup_res_t;

endpackage

// ----- rtl/core/sacl_if.sv -----
// valid/ready channels of the cache model: access, result and config write
interface sacl_access_if
    import sacl_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] address;

    modport source (output valid, output mode, output address, input ready);
    modport sink   (input valid, input mode, input address, output ready);
endinterface

interface sacl_result_if
    import sacl_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [OUTCOME_W-1:0] outcome;
    logic [HITS_W-1:0]    hits_added;
    logic [TOTAL_W-1:0]   total_hits;
    logic [TOTAL_W-1:0]   total_misses;
    logic [TOTAL_W-1:0]   total_evictions;

    modport source (output valid, output outcome, output hits_added, output total_hits,
                    output total_misses, output total_evictions, input ready);
    modport sink   (input valid, input outcome, input hits_added, input total_hits,
                    input total_misses, input total_evictions, output ready);
endinterface

interface sacl_cfg_if
    import sacl_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/sacl_ram.sv -----
// generic single-write, single-read ram with registered read data
module sacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/sacl_lru.sv -----
// tag match, victim choice and age update over one set row
module sacl_lru
    import sacl_pkg::*;
#(
    parameter int MAX_WAYS = DEF_MAX_WAYS,
    localparam int AGE_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
    localparam int ENT_W = TAG_W + AGE_W + 1,
    localparam int ROW_W = MAX_WAYS * ENT_W
) (
    input  logic                row_init,
    input  logic [ROW_W-1:0]    row_rd,
    input  logic [MAX_WAYS-1:0] active,
    input  logic [TAG_W-1:0]    tag,
    input  logic                modify,
    output logic [ROW_W-1:0]    row_wr,
    output lookup_res_t         res
);

    localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(MAX_WAYS - 1);

    logic [MAX_WAYS-1:0] line_v;
    logic [AGE_W-1:0]    line_age [MAX_WAYS];
    logic [TAG_W-1:0]    line_tag [MAX_WAYS];
    logic [MAX_WAYS-1:0] match;
    logic [MAX_WAYS-1:0] free;
    logic                hit;
    logic                found_free;
    logic [WAY_W-1:0]    hit_way;
    logic [WAY_W-1:0]    free_way;
    logic [WAY_W-1:0]    victim;
    logic [AGE_W-1:0]    best;
    logic [WAY_W-1:0]    slot;
    logic [AGE_W-1:0]    old_age;

    // a row never written reads as all invalid with zero ages
    always_comb
    begin
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            line_v[i]   = row_init & row_rd[i*ENT_W + ENT_W - 1];
            line_age[i] = row_init ? row_rd[i*ENT_W + TAG_W +: AGE_W] : '0;
            line_tag[i] = row_rd[i*ENT_W +: TAG_W];
            match[i]    = active[i] & line_v[i] & (line_tag[i] == tag);
            free[i]     = active[i] & ~line_v[i];
        end
    end

    always_comb
    begin
        hit_way  = '0;
        free_way = '0;
        for (int i = MAX_WAYS - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit_way = WAY_W'(i);
            end
            if (free[i])
            begin
                free_way = WAY_W'(i);
            end
        end
    end

    // oldest active line, lowest way on a tie
    always_comb
    begin
        best   = '0;
        victim = '0;
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            if (active[i] && (i == 0 || line_age[i] > best))
            begin
                best   = line_age[i];
                victim = WAY_W'(i);
            end
        end
    end

    assign hit        = |match;
    assign found_free = |free;
    assign slot       = found_free ? free_way : victim;
    assign old_age    = line_age[hit_way];

    always_comb
    begin
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            row_wr[i*ENT_W +: ENT_W] = {line_v[i], line_age[i], line_tag[i]};
            if (hit)
            begin
                if (WAY_W'(i) == hit_way)
                begin
                    row_wr[i*ENT_W + TAG_W +: AGE_W] = '0;
                end
                else if (active[i] && line_v[i] && line_age[i] < old_age)
                begin
                    row_wr[i*ENT_W + TAG_W +: AGE_W] = line_age[i] + 1'b1;
                end
            end
            else
            begin
                if (WAY_W'(i) == slot)
                begin
                    row_wr[i*ENT_W +: ENT_W] = {1'b1, {AGE_W{1'b0}}, tag};
                end
                else if (active[i] && line_v[i] && line_age[i] < AGE_MAX)
                begin
                    row_wr[i*ENT_W + TAG_W +: AGE_W] = line_age[i] + 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        res.hit   = hit;
        res.evict = ~hit & ~found_free;
        if (hit)
        begin
            res.hits_added = modify ? HITS_W'(2) : HITS_W'(1);
        end
        else
        begin
            res.hits_added = modify ? HITS_W'(1) : HITS_W'(0);
        end
    end

endmodule

// ----- rtl/core/sacl_stats.sv -----
// saturating hit, miss and eviction totals
module sacl_stats
    import sacl_pkg::*;
#(
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               upd,
    input  lookup_res_t        res,
    output logic [TOTAL_W-1:0] total_hits,
    output logic [TOTAL_W-1:0] total_misses,
    output logic [TOTAL_W-1:0] total_evictions
);

    logic [COUNT_WIDTH-1:0] hit_total_reg;
    logic [COUNT_WIDTH-1:0] miss_total_reg;
    logic [COUNT_WIDTH-1:0] evict_total_reg;
    logic [COUNT_WIDTH-1:0] hit_total_next;
    logic [COUNT_WIDTH-1:0] miss_total_next;
    logic [COUNT_WIDTH-1:0] evict_total_next;
    logic [63:0]            hits_wide;
    logic [63:0]            misses_wide;
    logic [63:0]            evictions_wide;

    function automatic logic [COUNT_WIDTH-1:0] sat_add(
        input logic [COUNT_WIDTH-1:0] total,
        input logic [HITS_W-1:0]      n
    );
        logic [COUNT_WIDTH:0] sum;
        sum = {1'b0, total} + (COUNT_WIDTH + 1)'(n);
        return sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : sum[COUNT_WIDTH-1:0];
    endfunction

    assign hit_total_next   = sat_add(hit_total_reg, res.hits_added);
    assign miss_total_next  = sat_add(miss_total_reg, HITS_W'(!res.hit));
    assign evict_total_next = sat_add(evict_total_reg, HITS_W'(res.evict));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_total_reg   <= '0;
            miss_total_reg  <= '0;
            evict_total_reg <= '0;
        end
        else if (upd)
        begin
            hit_total_reg   <= hit_total_next;
            miss_total_reg  <= miss_total_next;
            evict_total_reg <= evict_total_next;
        end
    end

    // reported in the low word, zero-padded for narrow counters
    assign hits_wide       = 64'(hit_total_reg);
    assign misses_wide     = 64'(miss_total_reg);
    assign evictions_wide  = 64'(evict_total_reg);
    assign total_hits      = hits_wide[TOTAL_W-1:0];
    assign total_misses    = misses_wide[TOTAL_W-1:0];
    assign total_evictions = evictions_wide[TOTAL_W-1:0];

endmodule

// ----- rtl/core/set_assoc_lru_cache_sim.sv -----
// top level of the set-associative lru cache model
//
//  channel   dir   word                                         accepted when
//  access    in    mode, address                                valid && ready
//  result    out   outcome, hits_added, total_hits/misses/evictions  valid && ready
//  cfg       in    index, data (set_bits, block_bits, ways_in_use)   valid && ready
//
// an access reads its set row from the tag ram as it is taken, then in the lookup
// state compares, updates ages and writes the row back; the next access is taken
// the cycle after the write, so no new access is taken while one is in flight.
// mode 3 is accepted but starts no lookup and gives no word.
// a row valid flip-flop per set is cleared by reset; there is no clearing pass.
// a held result word stalls only the write-back cycle of the following access.
module set_assoc_lru_cache_sim
    import sacl_pkg::*;
#(
    parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = DEF_MAX_WAYS,
    parameter int COUNT_WIDTH  = DEF_COUNT_WIDTH,
    localparam int NUM_SETS = 1 << MAX_SET_BITS,
    localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1,
    localparam int AGE_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
    localparam int ENT_W    = TAG_W + AGE_W + 1,
    localparam int ROW_W    = MAX_WAYS * ENT_W,
    localparam int WAYS_W   = $clog2(MAX_WAYS + 1)
) (
    input  logic            clk,
    input  logic            rst_n,
    sacl_access_if.sink     access,
    sacl_result_if.source   result,
    sacl_cfg_if.sink        cfg
);

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_LOOKUP = 2'b10
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    logic [SET_BITS_W-1:0]   set_bits_reg;
    logic [BLOCK_BITS_W-1:0] block_bits_reg;
    logic [WAYS_CFG_W-1:0]   ways_reg;
    logic [NUM_SETS-1:0]     row_init_reg;
    logic [TAG_W-1:0]        tag_reg;
    logic [SET_W-1:0]        set_reg;
    logic                    modify_reg;
    logic                    init_reg;
    logic                    out_valid_reg;
    logic [OUTCOME_W-1:0]    outcome_reg;
    logic [HITS_W-1:0]       hits_added_reg;

    logic [2:0]              sb;
    logic [6:0]              shift;
    logic [ADDR_W-1:0]       addr_shift;
    logic [SET_W:0]          set_mask;
    logic [SET_W-1:0]        acc_set;
    logic [TAG_W-1:0]        acc_tag;
    logic                    accept;
    logic                    start;
    logic                    fire;
    logic [WAYS_W-1:0]       ways_eff;
    logic [MAX_WAYS-1:0]     active;
    logic [ROW_W-1:0]        row_rd;
    logic [ROW_W-1:0]        row_wr;
    lookup_res_t             res;
    outcome_t                outcome_next;

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg   <= SET_BITS_RST;
            block_bits_reg <= BLOCK_BITS_RST;
            ways_reg       <= WAYS_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_idx_t'(cfg.index))
                CFG_SET_BITS:   set_bits_reg   <= cfg.data[SET_BITS_W-1:0];
                CFG_BLOCK_BITS: block_bits_reg <= cfg.data[BLOCK_BITS_W-1:0];
                CFG_WAYS:       ways_reg       <= cfg.data[WAYS_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // address split
    always_comb
    begin
        if (int'(set_bits_reg) > MAX_SET_BITS)
        begin
            sb = 3'(MAX_SET_BITS);
        end
        else
        begin
            sb = set_bits_reg;
        end
        shift      = 7'(sb) + 7'(block_bits_reg);
        addr_shift = access.address >> block_bits_reg;
        set_mask   = ((SET_W + 1)'(1) << sb) - 1'b1;
        acc_set    = addr_shift[SET_W-1:0] & set_mask[SET_W-1:0];
        acc_tag    = shift[6] ? '0 : (access.address >> shift[5:0]);
    end

    always_comb
    begin
        if (ways_reg == '0)
        begin
            ways_eff = WAYS_W'(1);
        end
        else if (int'(ways_reg) > MAX_WAYS)
        begin
            ways_eff = WAYS_W'(MAX_WAYS);
        end
        else
        begin
            ways_eff = WAYS_W'(ways_reg);
        end
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            active[i] = i < int'(ways_eff);
        end
    end

    // control
    assign access.ready = (state_reg == ST_IDLE);
    assign accept       = access.valid && access.ready;
    assign start        = accept && (mode_t'(access.mode) != MODE_UNUSED);
    assign fire         = (state_reg == ST_LOOKUP) && (!out_valid_reg || result.ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_init_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (fire)
            begin
                row_init_reg[set_reg] <= 1'b1;
                out_valid_reg         <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // the row written back last cycle is already visible to this read
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            tag_reg    <= acc_tag;
            set_reg    <= acc_set;
            modify_reg <= (mode_t'(access.mode) == MODE_MODIFY);
            init_reg   <= row_init_reg[acc_set];
        end
        if (fire)
        begin
            outcome_reg    <= outcome_next;
            hits_added_reg <= res.hits_added;
        end
    end

    always_comb
    begin
        if (res.hit)
        begin
            outcome_next = OUTCOME_HIT;
        end
        else if (res.evict)
        begin
            outcome_next = OUTCOME_EVICT;
        end
        else
        begin
            outcome_next = OUTCOME_MISS;
        end
    end

    sacl_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_tag_ram (
        .clk   (clk),
        .we    (fire),
        .waddr (set_reg),
        .wdata (row_wr),
        .re    (start),
        .raddr (acc_set),
        .rdata (row_rd)
    );

    sacl_lru #(
        .MAX_WAYS (MAX_WAYS)
    ) u_lru (
        .row_init (init_reg),
        .row_rd   (row_rd),
        .active   (active),
        .tag      (tag_reg),
        .modify   (modify_reg),
        .row_wr   (row_wr),
        .res      (res)
    );

    sacl_stats #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_stats (
        .clk             (clk),
        .rst_n           (rst_n),
        .upd             (fire),
        .res             (res),
        .total_hits      (result.total_hits),
        .total_misses    (result.total_misses),
        .total_evictions (result.total_evictions)
    );

    assign result.valid      = out_valid_reg;
    assign result.outcome    = outcome_reg;
    assign result.hits_added = hits_added_reg;

endmodule

// ----- rtl/core/sacl_checker.sv -----
// port-level checks of the cache model, bound to the top level
module sacl_checker
    import sacl_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 access_valid,
    input logic                 access_ready,
    input logic [MODE_W-1:0]    access_mode,
    input logic                 result_valid,
    input logic                 result_ready,
    input logic [OUTCOME_W-1:0] result_outcome,
    input logic [HITS_W-1:0]    result_hits_added,
    input logic [TOTAL_W-1:0]   result_total_hits,
    input logic [TOTAL_W-1:0]   result_total_misses,
    input logic [TOTAL_W-1:0]   result_total_evictions
);

    logic real_access;

    assign real_access = access_valid && access_ready && (access_mode != MODE_UNUSED);

    // the write-back cycle blocks the next access
    a_busy_after_access: assert property (
        @(posedge clk) disable iff (!rst_n)
        real_access |=> !access_ready
    ) else $error("access taken during write-back cycle");

    // with the output slot free, the lookup of an access is not stalled and its word is registered into the output slot
    a_result_latency: assert property (
        @(posedge clk) disable iff (!rst_n)
        (real_access && !result_valid) |-> ##2 result_valid
    ) else $error("result word missing after access");

    a_result_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> result_valid
    ) else $error("result word dropped while stalled");

    // totals must not move under a stalled word
    a_result_stable: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=>
            ($stable(result_outcome) && $stable(result_hits_added) &&
             $stable(result_total_hits) && $stable(result_total_misses) &&
             $stable(result_total_evictions))
    ) else $error("result word changed while stalled");

endmodule

bind set_assoc_lru_cache_sim sacl_checker u_sacl_checker (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .access_valid           (access.valid),
    .access_ready           (access.ready),
    .access_mode            (access.mode),
    .result_valid           (result.valid),
    .result_ready           (result.ready),
    .result_outcome         (result.outcome),
    .result_hits_added      (result.hits_added),
    .result_total_hits      (result.total_hits),
    .result_total_misses    (result.total_misses),
    .result_total_evictions (result.total_evictions)
);
